// File: hw/rtl/ewrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewrq_pkg
// Shared types, constants and helpers for the event wake ready queue.
// ----------------------------------------------------------------------------
package ewrq_pkg;

  // field widths
  localparam int SRC_W  = 10;
  localparam int TASK_W = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;
  localparam int SLOT_W = TASK_W + 1;

  // table sizes
  localparam int NUM_SOURCES = 1024;
  localparam int SRC_AW      = $clog2(NUM_SOURCES);
  localparam int MAX_TASKS   = 64;
  localparam int PTR_W       = $clog2(MAX_TASKS);

  // short queues between the parts
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // source range check limit
  localparam logic [SRC_W:0] SRC_LIMIT = (SRC_W + 1)'(NUM_SOURCES);

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_PARK   = 2'd0,
    OP_UNPARK = 2'd1,
    OP_WAKE   = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t              op;
    logic             src_ok;
    logic [SRC_W-1:0] source;
    logic [TASK_W-1:0] task_id;
  } cmd_t;

  // back status seen by the front
  typedef struct packed {
    logic take;
    logic clearing;
  } back_stat_t;

  // one result
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TASK_W-1:0] task_id;
    logic [CNT_W-1:0]  count;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(MAX_TASKS - 1) : p - 1'b1;
  endfunction

  function automatic logic [QAW-1:0] q_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/event_wake_ready_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_wake_ready_queue_unit
// Task wake scheduler: per-source wait table feeding a ready deque.
// ----------------------------------------------------------------------------
// usage
//   request side: drive in_opcode, in_source, in_task_id and raise push; the
//   request is taken on a clock edge with push high and full low.
//   result side: while empty is low the oldest result sits on out_status,
//   out_result_task and out_ready_count; pop high takes it. exactly one
//   result per request, in request order.
//   config: cfg_wake_policy is written when cfg_valid is high (cfg_ready is
//   always high); write only while no request is in flight.
// execution
//   each request has its wait table read in the idle state, then its table or
//   deque update in the exec state; the next request is not taken before the
//   exec state ends.
// reset
//   after rst_n the wait table is swept clear, one slot per cycle, over all
//   1024 slots; full stays high during the sweep. wake policy resets to lifo.
// stall
//   a two-entry request queue and a two-entry result queue decouple the
//   sides; when results are not taken the unit stops and full rises.
// ----------------------------------------------------------------------------
module event_wake_ready_queue_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [ewrq_pkg::SRC_W-1:0]  in_source,
  input  wire logic [ewrq_pkg::TASK_W-1:0] in_task_id,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [ewrq_pkg::STAT_W-1:0]     out_status,
  output logic [ewrq_pkg::TASK_W-1:0]     out_result_task,
  output logic [ewrq_pkg::CNT_W-1:0]      out_ready_count,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_wake_policy
);
  import ewrq_pkg::*;

  logic       cmd_valid;
  cmd_t       cmd;
  back_stat_t stat;

  assign cfg_ready = 1'b1;

  // request intake and classification
  ewrq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_opcode  (in_opcode),
    .in_source  (in_source),
    .in_task_id (in_task_id),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .stat       (stat)
  );

  // execution and result queue
  ewrq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_wake_policy (cfg_wake_policy),
    .pop             (pop),
    .empty           (empty),
    .out_status      (out_status),
    .out_result_task (out_result_task),
    .out_ready_count (out_ready_count)
  );

endmodule
`default_nettype wire

// File: hw/rtl/ewrq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewrq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ewrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/ewrq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewrq_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module ewrq_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [ewrq_pkg::SRC_W-1:0]  in_source,
  input  wire logic [ewrq_pkg::TASK_W-1:0] in_task_id,
  output logic                            cmd_valid,
  output ewrq_pkg::cmd_t                  cmd,
  input  wire ewrq_pkg::back_stat_t       stat
);
  import ewrq_pkg::*;

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           accept;
  cmd_t           cmd_new;

  // no request taken while the wait table is being cleared
  assign full   = (cnt_r == QCW'(QDEPTH)) || stat.clearing;
  assign accept = push && !full;

  // classify the incoming request
  always_comb begin
    cmd_new.op      = op_t'(in_opcode);
    cmd_new.src_ok  = {1'b0, in_source} < SRC_LIMIT;
    cmd_new.source  = in_source;
    cmd_new.task_id = in_task_id;
  end

  // queue pointers
  always_comb begin
    wr_nxt  = accept ? q_inc(wr_r) : wr_r;
    rd_nxt  = stat.take ? q_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + QCW'(accept) - QCW'(stat.take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_r] <= cmd_new;
    end
  end

  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];

endmodule
`default_nettype wire

// File: hw/rtl/ewrq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewrq_back
// Executes requests on the wait table and the ready deque, queues results.
// ----------------------------------------------------------------------------
module ewrq_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cmd_valid,
  input  wire ewrq_pkg::cmd_t             cmd,
  output ewrq_pkg::back_stat_t            stat,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_wake_policy,
  input  wire logic                       pop,
  output logic                            empty,
  output logic [ewrq_pkg::STAT_W-1:0]     out_status,
  output logic [ewrq_pkg::TASK_W-1:0]     out_result_task,
  output logic [ewrq_pkg::CNT_W-1:0]      out_ready_count
);
  import ewrq_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [SRC_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic              policy_r, policy_nxt;

  logic              take;
  logic              wt_we;
  logic [SRC_AW-1:0] wt_waddr;
  logic [SLOT_W-1:0] wt_wdata;
  logic [SLOT_W-1:0] wt_rdata;
  logic              rs_we;
  logic [PTR_W-1:0]  rs_waddr;
  logic [TASK_W-1:0] rs_rdata;

  res_t              res_q_r [QDEPTH];
  logic [QAW-1:0]    res_wr_r, res_rd_r;
  logic [QCW-1:0]    res_cnt_r;
  logic              res_push;
  logic              res_pop;
  res_t              res_new;

  // wait table: one slot per source, valid bit over task id
  ewrq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SOURCES)) u_wait_tbl (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (cmd.source[SRC_AW-1:0]),
    .rdata (wt_rdata)
  );

  // ready deque storage, always read at the head
  ewrq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_ready_store (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (wt_rdata[TASK_W-1:0]),
    .raddr (head_r),
    .rdata (rs_rdata)
  );

  assign res_pop = pop && (res_cnt_r != '0);

  // sequencer: clear pass, fetch, execute
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    cmd_nxt         = cmd_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    occ_nxt         = occ_r;
    policy_nxt      = cfg_valid ? cfg_wake_policy : policy_r;
    take            = 1'b0;
    wt_we           = 1'b0;
    wt_waddr        = cmd_r.source[SRC_AW-1:0];
    wt_wdata        = '0;
    rs_we           = 1'b0;
    rs_waddr        = tail_r;
    res_push        = 1'b0;
    res_new.status  = STAT_NONE;
    res_new.task_id = '0;
    case (state_r)
      ST_CLEAR: begin
        wt_we    = 1'b1;
        wt_waddr = clr_cnt_r;
        if (clr_cnt_r == SRC_AW'(NUM_SOURCES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && (res_cnt_r != QCW'(QDEPTH))) begin
          take      = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
        case (cmd_r.op)
          OP_PARK: begin
            if (cmd_r.src_ok) begin
              wt_we          = 1'b1;
              wt_wdata       = {1'b1, cmd_r.task_id};
              res_new.status = STAT_DONE;
            end
          end
          OP_UNPARK: begin
            if (cmd_r.src_ok && (wt_rdata == {1'b1, cmd_r.task_id})) begin
              wt_we          = 1'b1;
              res_new.status = STAT_DONE;
            end
          end
          OP_WAKE: begin
            if (cmd_r.src_ok && wt_rdata[TASK_W]) begin
              if (occ_r != CNT_W'(MAX_TASKS)) begin
                rs_we = 1'b1;
                if (policy_r) begin
                  rs_waddr = ptr_dec(head_r);
                  head_nxt = ptr_dec(head_r);
                end else begin
                  tail_nxt = ptr_inc(tail_r);
                end
                occ_nxt         = occ_r + 1'b1;
                res_new.status  = STAT_DONE;
                res_new.task_id = wt_rdata[TASK_W-1:0];
              end else begin
                res_new.status = STAT_FULL;
              end
            end
          end
          OP_POP: begin
            if (occ_r != '0) begin
              head_nxt        = ptr_inc(head_r);
              occ_nxt         = occ_r - 1'b1;
              res_new.status  = STAT_DONE;
              res_new.task_id = rs_rdata;
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
    res_new.count = occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      occ_r     <= '0;
      policy_r  <= 1'b1;
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      occ_r     <= occ_nxt;
      policy_r  <= policy_nxt;
      res_wr_r  <= res_push ? q_inc(res_wr_r) : res_wr_r;
      res_rd_r  <= res_pop ? q_inc(res_rd_r) : res_rd_r;
      res_cnt_r <= res_cnt_r + QCW'(res_push) - QCW'(res_pop);
    end
  end

  // request payload and result storage
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (res_push) begin
      res_q_r[res_wr_r] <= res_new;
    end
  end

  assign stat.take     = take;
  assign stat.clearing = (state_r == ST_CLEAR);

  assign empty           = (res_cnt_r == '0);
  assign out_status      = res_q_r[res_rd_r].status;
  assign out_result_task = res_q_r[res_rd_r].task_id;
  assign out_ready_count = res_q_r[res_rd_r].count;

endmodule
`default_nettype wire

// File: hw/rtl/ewrq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewrq_checker
// Port-level checks on the result channel of the ready queue unit.
// ----------------------------------------------------------------------------
module ewrq_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       empty,
  input wire logic                       pop,
  input wire logic [ewrq_pkg::STAT_W-1:0] out_status,
  input wire logic [ewrq_pkg::TASK_W-1:0] out_result_task,
  input wire logic [ewrq_pkg::CNT_W-1:0]  out_ready_count
);
  import ewrq_pkg::*;

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == STAT_DONE || out_status == STAT_NONE ||
                out_status == STAT_FULL))
    else $error("undefined result status");

  // deque never reports more than its capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_ready_count <= CNT_W'(MAX_TASKS)))
    else $error("ready count above capacity");

  // a failed request carries no task
  a_fail_no_task: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status != STAT_DONE)) |-> (out_result_task == '0))
    else $error("task reported on a failed request");

  // a dropped push only happens with the deque full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == STAT_FULL)) |-> (out_ready_count == CNT_W'(MAX_TASKS)))
    else $error("push dropped while deque not full");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) &&
                          $stable(out_result_task) && $stable(out_ready_count)))
    else $error("waiting result changed");

endmodule

bind event_wake_ready_queue_unit ewrq_checker u_ewrq_checker (.*);
`default_nettype wire
